// File: hdl/bqf_pkg.sv
// bqf_pkg: shared widths, types and codes of the biquad low-pass / high-pass filter
// no dependencies
`default_nettype none

package bqf_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 28;
    localparam int OUT_BITS       = 24;
    localparam int MODE_BITS      = 2;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 32;

    // doubled sample, feedforward tap sum, products and accumulator
    localparam int X_BITS   = SAMPLE_BITS + 1;
    localparam int FF_BITS  = SAMPLE_BITS + 3;
    localparam int FFP_BITS = COEF_BITS + FF_BITS;
    localparam int FB_BITS  = COEF_BITS + OUT_BITS;
    localparam int ACC_BITS = FB_BITS + 2;
    localparam int YF_BITS  = ACC_BITS - COEF_FRAC_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [OUT_BITS-1:0]    out_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic        [MODE_BITS-1:0]   mode_t;

    localparam mode_t MODE_LOWPASS  = 2'd0;
    localparam mode_t MODE_HIGHPASS = 2'd1;
    localparam mode_t MODE_BYPASS   = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B0     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A1     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A2     = 2'd3;

    localparam out_t OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam out_t OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

endpackage

`default_nettype wire

// File: hdl/bqf_if.sv
// bqf_if: valid/ready stream channels for input samples and filter results
// depends on bqf_pkg
`default_nettype none

interface bqf_in_if;
    logic              valid;
    logic              ready;
    bqf_pkg::sample_t  sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqf_out_if;
    logic           valid;
    logic           ready;
    bqf_pkg::out_t  sample_out;
    logic           clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

// File: hdl/biquad_lowpass_highpass_filter.sv
// biquad_lowpass_highpass_filter: direct-form-I biquad over a 16-bit sample stream
// depends on bqf_pkg and bqf_if
//
// samples: sink channel, one signed 16-bit audio sample per beat
// results: source channel, one beat per sample: 24-bit sample_out and clipped
// cfg_we / cfg_index / cfg_data: register writes, taken at any edge with cfg_we high
//   0 filter_mode (0 low-pass, 1 high-pass, 2 or 3 bypass), 1 b0, 2 a1, 3 a2 (Q3.28)
//   write only while no sample is in flight
// three register stages: input, feedforward product, result
//   one sample per cycle sustained while results.ready is high; the a1 product,
//   round and saturate close the output history combinationally at the result
//   stage, and the a2 product is registered ahead of its use
// bypass: raw sample sign-extended, clipped low, history left alone
// reset: mode bypass, coefficients and history zero, pipeline empty
// a stalled results channel holds its beat; the stages behind it fill and then
//   samples.ready falls, no beat is dropped
`default_nettype none

module biquad_lowpass_highpass_filter (
    input  wire                                   clk,
    input  wire                                   rst_n,
    bqf_in_if.sink                                samples,
    bqf_out_if.source                             results,
    input  wire                                   cfg_we,
    input  wire [bqf_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  wire [bqf_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    // configuration
    bqf_pkg::mode_t mode_reg;
    bqf_pkg::coef_t b0_reg;
    bqf_pkg::coef_t a1_reg;
    bqf_pkg::coef_t a2_reg;

    // pipeline
    logic                                       in_v_reg;
    bqf_pkg::sample_t                           in_s_reg;
    logic                                       ff_v_reg;
    logic                                       ff_byp_reg;
    bqf_pkg::sample_t                           ff_s_reg;
    logic signed [bqf_pkg::FFP_BITS-1:0]        ff_prod_reg;
    logic                                       out_v_reg;
    bqf_pkg::out_t                              out_y_reg;
    logic                                       out_clip_reg;

    // history
    logic signed [bqf_pkg::X_BITS-1:0]          x1_reg;
    logic signed [bqf_pkg::X_BITS-1:0]          x2_reg;
    bqf_pkg::out_t                              y1_reg;
    bqf_pkg::out_t                              y2_reg;
    logic signed [bqf_pkg::FB_BITS-1:0]         pa2_reg;
    logic signed [bqf_pkg::FB_BITS-1:0]         pa2_next;

    localparam logic signed [bqf_pkg::ACC_BITS-1:0] RND =
        {{(bqf_pkg::ACC_BITS-bqf_pkg::COEF_FRAC_BITS){1'b0}}, 1'b1,
         {(bqf_pkg::COEF_FRAC_BITS-1){1'b0}}};

    logic adv_out;
    logic ff_free;
    logic in_free;
    logic mv_a;
    logic mv_b;
    logic hist_b;

    assign adv_out = !out_v_reg || results.ready;
    assign ff_free = !ff_v_reg || adv_out;
    assign in_free = !in_v_reg || ff_free;
    assign mv_a    = in_v_reg && ff_free;
    assign mv_b    = ff_v_reg && adv_out;
    assign hist_b  = mv_b && !ff_byp_reg;

    assign samples.ready      = in_free;
    assign results.valid      = out_v_reg;
    assign results.sample_out = out_y_reg;
    assign results.clipped    = out_clip_reg;

    // feedforward: b0 * (x +/- 2*x1 + x2)
    logic                                    a_bypass;
    logic signed [bqf_pkg::X_BITS-1:0]       x_cur;
    logic signed [bqf_pkg::FF_BITS-1:0]      ff_sum;
    logic signed [bqf_pkg::FFP_BITS-1:0]     ff_prod;

    always_comb
    begin
        a_bypass = mode_reg[1];
        x_cur    = {in_s_reg, 1'b0};
        if (mode_reg == bqf_pkg::MODE_HIGHPASS)
        begin
            ff_sum = bqf_pkg::FF_BITS'(x_cur) - (bqf_pkg::FF_BITS'(x1_reg) <<< 1)
                   + bqf_pkg::FF_BITS'(x2_reg);
        end
        else
        begin
            ff_sum = bqf_pkg::FF_BITS'(x_cur) + (bqf_pkg::FF_BITS'(x1_reg) <<< 1)
                   + bqf_pkg::FF_BITS'(x2_reg);
        end
        ff_prod = b0_reg * ff_sum;
    end

    // feedback, round, saturate
    logic signed [bqf_pkg::FB_BITS-1:0]      fb1;
    logic signed [bqf_pkg::ACC_BITS-1:0]     acc;
    logic signed [bqf_pkg::YF_BITS-1:0]      y_full;
    logic                                    sat_hi;
    logic                                    sat_lo;
    bqf_pkg::out_t                           y_sat;

    always_comb
    begin
        fb1    = a1_reg * y1_reg;
        acc    = bqf_pkg::ACC_BITS'(ff_prod_reg) - bqf_pkg::ACC_BITS'(fb1)
               - bqf_pkg::ACC_BITS'(pa2_reg) + RND;
        y_full = acc[bqf_pkg::ACC_BITS-1:bqf_pkg::COEF_FRAC_BITS];
        sat_hi = !y_full[bqf_pkg::YF_BITS-1]
                 && (|y_full[bqf_pkg::YF_BITS-2:bqf_pkg::OUT_BITS-1]);
        sat_lo = y_full[bqf_pkg::YF_BITS-1]
                 && !(&y_full[bqf_pkg::YF_BITS-2:bqf_pkg::OUT_BITS-1]);
        if (sat_hi)
        begin
            y_sat = bqf_pkg::OUT_MAX;
        end
        else if (sat_lo)
        begin
            y_sat = bqf_pkg::OUT_MIN;
        end
        else
        begin
            y_sat = y_full[bqf_pkg::OUT_BITS-1:0];
        end
    end

    // a2 * y2 for the next sample, registered ahead of its use
    bqf_pkg::coef_t a2_sel;
    bqf_pkg::out_t  y2_sel;

    always_comb
    begin
        a2_sel   = (cfg_we && cfg_index == bqf_pkg::REG_COEF_A2) ? cfg_data : a2_reg;
        y2_sel   = hist_b ? y1_reg : y2_reg;
        pa2_next = a2_sel * y2_sel;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bqf_pkg::MODE_BYPASS;
            b0_reg   <= '0;
            a1_reg   <= '0;
            a2_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bqf_pkg::REG_FILTER_MODE: mode_reg <= cfg_data[bqf_pkg::MODE_BITS-1:0];
                bqf_pkg::REG_COEF_B0:     b0_reg   <= cfg_data;
                bqf_pkg::REG_COEF_A1:     a1_reg   <= cfg_data;
                bqf_pkg::REG_COEF_A2:     a2_reg   <= cfg_data;
                default:                  mode_reg <= mode_reg;
            endcase
        end
    end

    // control and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            ff_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            x1_reg    <= '0;
            x2_reg    <= '0;
            y1_reg    <= '0;
            y2_reg    <= '0;
            pa2_reg   <= '0;
        end
        else
        begin
            if (in_free)
            begin
                in_v_reg <= samples.valid;
            end
            if (ff_free)
            begin
                ff_v_reg <= in_v_reg;
            end
            if (adv_out)
            begin
                out_v_reg <= ff_v_reg;
            end
            if (mv_a && !a_bypass)
            begin
                x2_reg <= x1_reg;
                x1_reg <= x_cur;
            end
            if (hist_b)
            begin
                y2_reg <= y1_reg;
                y1_reg <= y_sat;
            end
            pa2_reg <= pa2_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (samples.valid && in_free)
        begin
            in_s_reg <= samples.sample_in;
        end
        if (mv_a)
        begin
            ff_s_reg    <= in_s_reg;
            ff_byp_reg  <= a_bypass;
            ff_prod_reg <= ff_prod;
        end
        if (mv_b)
        begin
            if (ff_byp_reg)
            begin
                out_y_reg    <= bqf_pkg::OUT_BITS'(ff_s_reg);
                out_clip_reg <= 1'b0;
            end
            else
            begin
                out_y_reg    <= y_sat;
                out_clip_reg <= sat_hi || sat_lo;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/bqf_checker.sv
// bqf_checker: port-level checks of the biquad filter, bound to the top level
// depends on bqf_pkg
`default_nettype none

module bqf_checker (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     in_valid,
    input wire                     in_ready,
    input wire                     out_valid,
    input wire                     out_ready,
    input wire [bqf_pkg::OUT_BITS-1:0] sample_out,
    input wire                     clipped
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(clipped))
        else $error("result beat changed while stalled");

    // no result without a sample in flight
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result beat without a pending sample");

    // at most three samples inside the pipeline
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("more samples in flight than stages");

    // an empty pipeline always takes a sample
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd0 |-> in_ready)
        else $error("input not ready with empty pipeline");

    // a clipped result sits at a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> sample_out == bqf_pkg::OUT_MAX
                                 || sample_out == bqf_pkg::OUT_MIN)
        else $error("clipped result not at a saturation limit");

endmodule

bind biquad_lowpass_highpass_filter bqf_checker u_bqf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .sample_out (results.sample_out),
    .clipped    (results.clipped)
);

`default_nettype wire
